@@ rtl/rgbhsl_pkg.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_pkg
// Shared widths and constants of the RGB to HSL converter.
// ----------------------------------------------------------------------------
package rgbhsl_pkg;

  localparam int CH_W   = 8;   // one color channel
  localparam int HUE_W  = 15;  // hue in 1/64 degree
  localparam int SAT_W  = 13;  // saturation times 4096
  localparam int LSUM_W = 9;   // max plus min channel

  // long division: 24-bit dividend, 9-bit divisor, 15 quotient bits
  localparam int DIV_NW = 24;
  localparam int DIV_DW = 9;
  localparam int DIV_QW = 15;

  // one full turn in 1/64 degree
  localparam logic [HUE_W-1:0] HUE_FULL = 15'd23040;

endpackage

@@ rtl/rgbhsl_div.sv @@
// ----------------------------------------------------------------------------
// rgbhsl_div
// Pipelined restoring divider, one quotient bit per register stage.
// The dividend must be below the divisor times 2**QW.
// ----------------------------------------------------------------------------
module rgbhsl_div #(
  parameter int NW = rgbhsl_pkg::DIV_NW,
  parameter int DW = rgbhsl_pkg::DIV_DW,
  parameter int QW = rgbhsl_pkg::DIV_QW
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  logic [NW-1:0] rem_r [QW-1];
  logic [DW-1:0] den_r [QW-1];
  logic [QW-1:0] quo_r [QW];

  for (genvar s = 0; s < QW; s++) begin : g_step
    logic [NW-1:0] rem_in;
    logic [DW-1:0] den_in;
    logic [QW-1:0] quo_in;
    logic [NW:0]   dsh;
    logic [NW:0]   trial;

    if (s == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign rem_in = rem_r[s-1];
      assign den_in = den_r[s-1];
      assign quo_in = quo_r[s-1];
    end

    // divisor aligned to this stage's quotient bit
    assign dsh   = (NW+1)'(den_in) << (QW - 1 - s);
    assign trial = {1'b0, rem_in} - dsh;

    always_ff @(posedge clk) begin
      if (en) begin
        quo_r[s] <= quo_in | (QW'(!trial[NW]) << (QW - 1 - s));
      end
    end

    if (s < QW - 1) begin : g_carry
      always_ff @(posedge clk) begin
        if (en) begin
          rem_r[s] <= trial[NW] ? rem_in : trial[NW-1:0];
          den_r[s] <= den_in;
        end
      end
    end
  end

  assign quo = quo_r[QW-1];

endmodule

@@ rtl/rgb_to_hsl.sv @@
// ----------------------------------------------------------------------------
// rgb_to_hsl
// Converts 8-bit RGB pixels to fixed-point hue, saturation and lightness.
// ----------------------------------------------------------------------------
// Takes one pixel word per clock and returns one result word per clock, in
// order, while the output is not stalled. One stage finds max and min, one
// builds the dividends, two side-by-side 15-stage long dividers (one quotient
// bit per stage, for hue and saturation) do the work, and a last stage wraps
// the hue and registers the result. A stalled output word holds the whole
// pipeline, so in_stall follows out_valid and out_stall directly. Hue is in
// 1/64 degree, saturation in 1/4096, lightness_sum is max plus min.
module rgb_to_hsl (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic [rgbhsl_pkg::CH_W-1:0]    in_red,
  input  logic [rgbhsl_pkg::CH_W-1:0]    in_green,
  input  logic [rgbhsl_pkg::CH_W-1:0]    in_blue,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic [rgbhsl_pkg::HUE_W-1:0]   out_hue,
  output logic [rgbhsl_pkg::SAT_W-1:0]   out_saturation,
  output logic [rgbhsl_pkg::LSUM_W-1:0]  out_lightness_sum,
  output logic                           out_achromatic
);

  localparam int NW = rgbhsl_pkg::DIV_NW;
  localparam int DW = rgbhsl_pkg::DIV_DW;
  localparam int QW = rgbhsl_pkg::DIV_QW;

  // multiple of d added to the channel difference for the hue sector
  typedef enum logic [1:0] {
    OFS_0 = 2'd0,
    OFS_2 = 2'd1,
    OFS_4 = 2'd2,
    OFS_6 = 2'd3
  } ofs_t;

  logic en;
  assign en       = !(out_valid && out_stall);
  assign in_stall = !en;

  // ---------------- stage a: max, min, sector ----------------
  logic       red_max, green_max;
  logic [7:0] mx, mn;
  logic [8:0] diff;
  ofs_t       ofs;

  always_comb begin
    red_max   = (in_red >= in_green) && (in_red >= in_blue);
    green_max = !red_max && (in_green >= in_blue);
    mx = in_red;
    mn = in_red;
    if (in_green > mx) mx = in_green;
    if (in_blue > mx)  mx = in_blue;
    if (in_green < mn) mn = in_green;
    if (in_blue < mn)  mn = in_blue;
    if (red_max) begin
      diff = {1'b0, in_green} - {1'b0, in_blue};
      ofs  = (in_green >= in_blue) ? OFS_0 : OFS_6;
    end else if (green_max) begin
      diff = {1'b0, in_blue} - {1'b0, in_red};
      ofs  = OFS_2;
    end else begin
      diff = {1'b0, in_red} - {1'b0, in_green};
      ofs  = OFS_4;
    end
  end

  logic       va_r;
  logic [7:0] d_a_r;
  logic [8:0] sum_a_r;
  logic [8:0] diff_a_r;
  ofs_t       ofs_a_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_a_r    <= mx - mn;
      sum_a_r  <= {1'b0, mx} + {1'b0, mn};
      diff_a_r <= diff;
      ofs_a_r  <= ofs;
    end
  end

  // ---------------- stage b: dividends ----------------
  logic [10:0]   kd, n;
  logic [8:0]    den9;
  logic [7:0]    den;
  logic [NW-1:0] hue_num_nxt, sat_num_nxt;

  always_comb begin
    case (ofs_a_r)
      OFS_0:   kd = '0;
      OFS_2:   kd = {2'b0, d_a_r, 1'b0};
      OFS_4:   kd = {1'b0, d_a_r, 2'b0};
      OFS_6:   kd = {1'b0, d_a_r, 2'b0} + {2'b0, d_a_r, 1'b0};
      default: kd = '0;
    endcase
    n    = kd + {{2{diff_a_r[8]}}, diff_a_r};
    den9 = (sum_a_r <= 9'd255) ? sum_a_r : 9'd510 - sum_a_r;
    den  = den9[7:0];
    // 2*3840*n + d, rounding half up
    hue_num_nxt = {n, 13'b0} - {4'b0, n, 9'b0} + {16'b0, d_a_r};
    // 2*4096*d + den
    sat_num_nxt = {3'b0, d_a_r, 13'b0} + {16'b0, den};
  end

  logic          vb_r;
  logic [NW-1:0] hue_num_r, sat_num_r;
  logic [DW-1:0] hue_div_r, sat_div_r;
  logic [8:0]    sum_b_r;
  logic          grey_b_r;

  always_ff @(posedge clk) begin
    if (en) begin
      hue_num_r <= hue_num_nxt;
      sat_num_r <= sat_num_nxt;
      hue_div_r <= {d_a_r, 1'b0};
      sat_div_r <= {den, 1'b0};
      sum_b_r   <= sum_a_r;
      grey_b_r  <= (d_a_r == 8'd0);
    end
  end

  // ---------------- dividers ----------------
  logic [QW-1:0] hue_q, sat_q;

  rgbhsl_div #(.NW(NW), .DW(DW), .QW(QW)) u_hue_div (
    .clk (clk),
    .en  (en),
    .num (hue_num_r),
    .den (hue_div_r),
    .quo (hue_q)
  );

  rgbhsl_div #(.NW(NW), .DW(DW), .QW(QW)) u_sat_div (
    .clk (clk),
    .en  (en),
    .num (sat_num_r),
    .den (sat_div_r),
    .quo (sat_q)
  );

  // sideband line alongside the dividers
  logic       vl_r   [QW];
  logic [8:0] sum_l_r [QW];
  logic       grey_l_r [QW];

  always_ff @(posedge clk) begin
    if (en) begin
      sum_l_r[0]  <= sum_b_r;
      grey_l_r[0] <= grey_b_r;
      for (int i = 1; i < QW; i++) begin
        sum_l_r[i]  <= sum_l_r[i-1];
        grey_l_r[i] <= grey_l_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r      <= 1'b0;
      vb_r      <= 1'b0;
      out_valid <= 1'b0;
      for (int i = 0; i < QW; i++) vl_r[i] <= 1'b0;
    end else if (en) begin
      va_r    <= in_valid;
      vb_r    <= va_r;
      vl_r[0] <= vb_r;
      for (int i = 1; i < QW; i++) vl_r[i] <= vl_r[i-1];
      out_valid <= vl_r[QW-1];
    end
  end

  // ---------------- output stage ----------------
  logic [rgbhsl_pkg::HUE_W-1:0] hue_wrap;
  logic                         grey_o;

  assign grey_o   = grey_l_r[QW-1];
  assign hue_wrap = (hue_q >= rgbhsl_pkg::HUE_FULL) ? hue_q - rgbhsl_pkg::HUE_FULL : hue_q;

  always_ff @(posedge clk) begin
    if (en) begin
      out_hue           <= grey_o ? '0 : hue_wrap;
      out_saturation    <= grey_o ? '0 : sat_q[rgbhsl_pkg::SAT_W-1:0];
      out_lightness_sum <= sum_l_r[QW-1];
      out_achromatic    <= grey_o;
    end
  end

  // ---------------- assertions ----------------
  a_grey_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_achromatic |-> out_hue == '0 && out_saturation == '0)
    else $error("grey word with nonzero hue or saturation");

  a_hue_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_hue < rgbhsl_pkg::HUE_FULL)
    else $error("hue not wrapped");

  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_saturation <= 13'd4096)
    else $error("saturation above one");

  a_color_sum: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_achromatic |-> out_lightness_sum != 9'd0 && out_lightness_sum != 9'd510)
    else $error("colored word at black or white");

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |-> in_stall)
    else $error("input taken while output stalled");

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench for rgb_to_hsl
// Sends pixel words through the converter and checks every result word against
// an in-bench integer predictor of hue, saturation, lightness sum and the grey
// flag. Directed corner pixels come first, then an output hold-off that fills
// the pipeline, then random pixels under several idle and stall mixes.
// ----------------------------------------------------------------------------
module testbench;

  localparam int CH_W   = rgbhsl_pkg::CH_W;
  localparam int HUE_W  = rgbhsl_pkg::HUE_W;
  localparam int SAT_W  = rgbhsl_pkg::SAT_W;
  localparam int LSUM_W = rgbhsl_pkg::LSUM_W;
  localparam int unsigned HUE_FULL = 32'(rgbhsl_pkg::HUE_FULL);

  localparam int CLK_HALF    = 10;
  localparam int RESET_LEN   = 10;
  localparam int PIPE_DEPTH  = 18;
  localparam int CYCLE_LIMIT = 400000;
  localparam int MAX_REPORTS = 30;
  localparam int unsigned SEXTANT = 3840;   // 60 degrees in 1/64 degree
  localparam int unsigned SAT_ONE = 4096;
  localparam logic [CH_W-1:0] CORNER_LEVELS [6] =
    '{8'd0, 8'd1, 8'd127, 8'd128, 8'd254, 8'd255};

  typedef struct packed {
    logic [HUE_W-1:0]  hue;
    logic [SAT_W-1:0]  sat;
    logic [LSUM_W-1:0] lsum;
    logic              grey;
  } hsl_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [CH_W-1:0]   in_red;
  logic [CH_W-1:0]   in_green;
  logic [CH_W-1:0]   in_blue;
  logic              out_valid;
  logic              out_stall;
  logic [HUE_W-1:0]  out_hue;
  logic [SAT_W-1:0]  out_saturation;
  logic [LSUM_W-1:0] out_lightness_sum;
  logic              out_achromatic;

  hsl_t pending_hsl[$];
  int   send_idle_pct;
  int   stall_pct;
  int   hold_left;
  int   error_count;
  int   pixels_sent;
  int   results_seen;
  int   grey_seen;
  int   cycle_count;

  rgb_to_hsl dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_red            (in_red),
    .in_green          (in_green),
    .in_blue           (in_blue),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_hue           (out_hue),
    .out_saturation    (out_saturation),
    .out_lightness_sum (out_lightness_sum),
    .out_achromatic    (out_achromatic)
  );

  initial begin
    clk = 1'b0;
    forever #CLK_HALF clk = ~clk;
  end

  // integer hue / saturation / lightness of one pixel, rounded half up
  function automatic hsl_t convert_pixel(logic [CH_W-1:0] r, logic [CH_W-1:0] g,
                                         logic [CH_W-1:0] b);
    int unsigned rv, gv, bv, mx, mn, span, total, den, n, h, sq;
    hsl_t res;
    rv = 32'(r);
    gv = 32'(g);
    bv = 32'(b);
    mx = rv;
    mn = rv;
    if (gv > mx) mx = gv;
    if (bv > mx) mx = bv;
    if (gv < mn) mn = gv;
    if (bv < mn) mn = bv;
    span  = mx - mn;
    total = mx + mn;
    res = '0;
    res.lsum = total[LSUM_W-1:0];
    if (span == 0) begin
      res.grey = 1'b1;
    end else begin
      den = (total <= 255) ? total : 510 - total;
      sq  = (2 * SAT_ONE * span + den) / (2 * den);
      res.sat = sq[SAT_W-1:0];
      // ties for the maximum go to red, then green
      if (mx == rv) begin
        n = (gv >= bv) ? (gv - bv) : (6 * span - (bv - gv));
      end else if (mx == gv) begin
        n = 2 * span + bv - rv;
      end else begin
        n = 4 * span + rv - gv;
      end
      h = (2 * SEXTANT * n + span) / (2 * span);
      if (h >= HUE_FULL) h = h - HUE_FULL;
      res.hue = h[HUE_W-1:0];
    end
    return res;
  endfunction

  // called at a falling edge, returns at the falling edge after acceptance
  task automatic send_pixel(input logic [CH_W-1:0] r, input logic [CH_W-1:0] g,
                            input logic [CH_W-1:0] b);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_red   <= r;
    in_green <= g;
    in_blue  <= b;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    pending_hsl.push_back(convert_pixel(r, g, b));
    pixels_sent++;
    @(negedge clk);
  endtask

  task automatic send_shuffled(input logic [CH_W-1:0] hi, input logic [CH_W-1:0] mid,
                               input logic [CH_W-1:0] lo);
    case ($urandom_range(0, 5))
      0: send_pixel(hi, mid, lo);
      1: send_pixel(hi, lo, mid);
      2: send_pixel(mid, hi, lo);
      3: send_pixel(lo, hi, mid);
      4: send_pixel(mid, lo, hi);
      default: send_pixel(lo, mid, hi);
    endcase
  endtask

  // sender stops until every expected word is back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(negedge clk); while (pending_hsl.size() != 0);
  endtask

  task automatic random_pixels(input int count);
    int unsigned hi, mid, lo, s, top;
    logic [CH_W-1:0] r, g;
    for (int i = 0; i < count; i++) begin
      case ($urandom_range(0, 11))
        0, 1, 2, 3: begin
          send_pixel(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                     8'($urandom_range(0, 255)));
        end
        4: begin
          hi = $urandom_range(0, 255);
          send_pixel(8'(hi), 8'(hi), 8'(hi));
        end
        5: begin
          // two channels share the maximum
          hi = $urandom_range(1, 255);
          lo = $urandom_range(0, hi - 1);
          send_shuffled(8'(hi), 8'(hi), 8'(lo));
        end
        6: begin
          // two channels share the minimum
          lo = $urandom_range(0, 254);
          hi = $urandom_range(lo + 1, 255);
          send_shuffled(8'(hi), 8'(lo), 8'(lo));
        end
        7, 8: begin
          // max plus min near 255, where the saturation divisor folds over
          s   = $urandom_range(250, 260);
          top = (s > 255) ? 255 : s;
          hi  = $urandom_range((s + 1) / 2, top);
          lo  = s - hi;
          mid = $urandom_range(lo, hi);
          send_shuffled(8'(hi), 8'(mid), 8'(lo));
        end
        9: begin
          send_pixel(CORNER_LEVELS[$urandom_range(0, 5)], CORNER_LEVELS[$urandom_range(0, 5)],
                     CORNER_LEVELS[$urandom_range(0, 5)]);
        end
        default: begin
          // red on top with blue just above green: hue just under a full turn
          r = 8'($urandom_range(1, 255));
          g = 8'($urandom_range(0, 32'(r) - 1));
          send_pixel(r, g, g + 8'd1);
        end
      endcase
    end
  endtask

  task automatic test_directed_pixels();
    send_idle_pct = 0;
    stall_pct     = 0;
    send_pixel(8'd0, 8'd0, 8'd0);
    send_pixel(8'd255, 8'd255, 8'd255);
    send_pixel(8'd128, 8'd128, 8'd128);
    send_pixel(8'd255, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd255);
    send_pixel(8'd255, 8'd255, 8'd0);
    send_pixel(8'd0, 8'd255, 8'd255);
    send_pixel(8'd255, 8'd0, 8'd255);
    send_pixel(8'd1, 8'd0, 8'd0);
    send_pixel(8'd0, 8'd0, 8'd1);
    send_pixel(8'd255, 8'd254, 8'd254);
    send_pixel(8'd255, 8'd1, 8'd1);
    send_pixel(8'd255, 8'd0, 8'd1);
    send_pixel(8'd200, 8'd10, 8'd11);
    send_pixel(8'd128, 8'd127, 8'd0);
    send_pixel(8'd127, 8'd128, 8'd0);
    send_pixel(8'd0, 8'd127, 8'd128);
    send_pixel(8'd170, 8'd85, 8'd170);
    send_pixel(8'd85, 8'd170, 8'd170);
    send_pixel(8'd254, 8'd1, 8'd128);
    send_pixel(8'd1, 8'd2, 8'd3);
    drain_results();
  endtask

  // receiver holds off long enough for the pipeline to fill and stall its input
  task automatic test_output_hold_off();
    send_idle_pct = 0;
    stall_pct     = 0;
    @(posedge clk);
    hold_left = 6 * PIPE_DEPTH;
    @(negedge clk);
    random_pixels(60);
    drain_results();
  endtask

  task automatic test_random_streaming();
    send_idle_pct = 0;
    stall_pct     = 0;
    random_pixels(350);
    drain_results();
  endtask

  task automatic test_random_sparse_input();
    send_idle_pct = 86;
    stall_pct     = 0;
    random_pixels(200);
    drain_results();
  endtask

  task automatic test_random_heavy_stall();
    send_idle_pct = 0;
    stall_pct     = 86;
    random_pixels(200);
    drain_results();
  endtask

  task automatic test_random_light_both();
    send_idle_pct = 11;
    stall_pct     = 11;
    random_pixels(350);
    drain_results();
  endtask

  // receiver stall, with the hold-off counted down here
  always @(negedge clk) begin
    if (hold_left > 0) begin
      out_stall <= 1'b1;
      hold_left--;
    end else begin
      out_stall <= ($urandom_range(0, 99) < stall_pct);
    end
  end

  always @(posedge clk) begin
    hsl_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_hsl.size() == 0) begin
        error_count++;
        if (error_count <= MAX_REPORTS)
          $display("%0t: result word with nothing expected: hue %0d sat %0d lsum %0d grey %0b",
                   $time, out_hue, out_saturation, out_lightness_sum, out_achromatic);
      end else begin
        want = pending_hsl.pop_front();
        if (want.grey) grey_seen++;
        if (out_hue !== want.hue || out_saturation !== want.sat ||
            out_lightness_sum !== want.lsum || out_achromatic !== want.grey) begin
          error_count++;
          if (error_count <= MAX_REPORTS) begin
            if (out_hue !== want.hue)
              $display("%0t: hue expected %0d, got %0d", $time, want.hue, out_hue);
            if (out_saturation !== want.sat)
              $display("%0t: saturation expected %0d, got %0d", $time, want.sat,
                       out_saturation);
            if (out_lightness_sum !== want.lsum)
              $display("%0t: lightness_sum expected %0d, got %0d", $time, want.lsum,
                       out_lightness_sum);
            if (out_achromatic !== want.grey)
              $display("%0t: achromatic expected %0b, got %0b", $time, want.grey,
                       out_achromatic);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d words still expected", cycle_count,
               pending_hsl.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  initial begin
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_red        = '0;
    in_green      = '0;
    in_blue       = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_left     = 0;
    error_count   = 0;
    pixels_sent   = 0;
    results_seen  = 0;
    grey_seen     = 0;
    cycle_count   = 0;
    repeat (RESET_LEN) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    test_directed_pixels();
    test_output_hold_off();
    test_random_streaming();
    test_random_sparse_input();
    test_random_heavy_stall();
    test_random_light_both();

    stall_pct = 0;
    repeat (2 * PIPE_DEPTH) @(negedge clk);
    $display("covered %0d pixels (%0d grey) over directed corners, a full-pipeline hold-off",
             pixels_sent, grey_seen);
    $display("and random streams under four idle/stall mixes; %0d result words compared",
             results_seen);
    if (error_count == 0 && pending_hsl.size() == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
